>>> src/lgge_pkg.sv
// Shared constants, field layout and types for the life grid generation engine.
// Used by every module under src but lgge_lane; depends on nothing else.
package lgge_pkg;

    // Grid dimensions.
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int COL_W = MAX_COLUMNS;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 2);
    localparam int HGT_W = $clog2(MAX_ROWS + 1);
    localparam int WID_W = $clog2(MAX_COLUMNS + 1);

    // Configuration registers.
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;

    // Operation codes.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // Field widths and the layout of the input tdata.
    localparam int ROW_IDX_W = 6;
    localparam int OFFSET_W  = 6;
    localparam int PATTERN_W = 64;
    localparam int ROW_IDX_LSB = 0;
    localparam int OFFSET_LSB  = ROW_IDX_LSB + ROW_IDX_W;
    localparam int CELLS_LSB   = OFFSET_LSB + OFFSET_W;
    localparam int MASK_LSB    = CELLS_LSB + PATTERN_W;
    localparam int S_TDATA_W   = ((MASK_LSB + PATTERN_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = PATTERN_W;

    // Status codes.
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_BAD_ROW = 1'b1;

    // Control of the row store's ports.
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
    } ram_req_t;

endpackage

>>> src/lgge_lane.sv
// One column lane: applies the B3/S23 rule to a 3x3 neighbourhood.
// Depends on nothing but its ports.
module lgge_lane (
    input  logic [2:0] up,
    input  logic [2:0] mid,
    input  logic [2:0] down,
    output logic       alive_next
);

    logic [3:0] neighbours;

    assign neighbours = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
                      + 4'(mid[0]) + 4'(mid[2])
                      + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);

    assign alive_next = (neighbours == 4'd3) || (mid[1] && (neighbours == 4'd2));

endmodule

>>> src/lgge_row_unit.sv
// Next-generation row: one lane per column, merged into a row and cut to the active width.
// Depends on lgge_pkg and lgge_lane.
module lgge_row_unit (
    input  logic [lgge_pkg::COL_W-1:0] up_row,
    input  logic [lgge_pkg::COL_W-1:0] mid_row,
    input  logic [lgge_pkg::COL_W-1:0] down_row,
    input  logic [lgge_pkg::COL_W-1:0] col_mask,
    output logic [lgge_pkg::COL_W-1:0] new_row
);

    localparam int N = lgge_pkg::COL_W;

    // Rows padded with a dead column on each side.
    logic [N+1:0] up_pad;
    logic [N+1:0] mid_pad;
    logic [N+1:0] down_pad;
    logic [N-1:0] lane_out;

    assign up_pad   = {1'b0, up_row, 1'b0};
    assign mid_pad  = {1'b0, mid_row, 1'b0};
    assign down_pad = {1'b0, down_row, 1'b0};

    for (genvar c = 0; c < N; c++) begin : g_lane
        lgge_lane u_lane (
            .up         (up_pad[c+2:c]),
            .mid        (mid_pad[c+2:c]),
            .down       (down_pad[c+2:c]),
            .alive_next (lane_out[c])
        );
    end

    assign new_row = lane_out & col_mask;

endmodule

>>> src/lgge_row_store.sv
// Row store of the grid: one write and one registered read port, per-row valid bits.
// Depends on lgge_pkg; a row never written since reset reads as all dead.
module lgge_row_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lgge_pkg::ram_req_t         req,
    input  logic [lgge_pkg::COL_W-1:0] wr_data,
    output logic [lgge_pkg::COL_W-1:0] rd_data
);

    logic [lgge_pkg::COL_W-1:0]  mem [lgge_pkg::MAX_ROWS];
    logic [lgge_pkg::MAX_ROWS-1:0] valid_reg;
    logic [lgge_pkg::COL_W-1:0]  q_reg;
    logic                        qv_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            qv_reg    <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                qv_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = qv_reg ? q_reg : '0;

endmodule

>>> src/life_grid_generation_engine.sv
// Life grid generation engine: a grid of one-bit cells with row write, row read and
// B3/S23 generation step. Depends on lgge_pkg, lgge_row_store and lgge_row_unit.
//
// Each input word is an operation in s_tuser and its fields in s_tdata; each one gives
// exactly one result word. A read or a write uses one read of the row store and passes
// through the access and deliver states to the result register; a flagged row index or an
// unused operation goes straight to the deliver state. A step walks the row store once,
// one row read and one row written per cycle with all columns computed by parallel lanes,
// then delivers its result. One word is worked on at a time; the next is accepted
// while the previous result still waits in the output register.
// Reset clears the grid at once through per-row valid bits, with no clearing pass.
module life_grid_generation_engine (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [lgge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgge_pkg::CFG_W-1:0]      cfg_wr_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: row_index, column_offset, row_cells, row_mask, zero padding.
    input  logic [lgge_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: operation.
    input  logic [lgge_pkg::OP_W-1:0]       s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: row_cells_out.
    output logic [lgge_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: status.
    output logic                            m_tuser
);

    localparam int COL_W = lgge_pkg::COL_W;
    localparam int ROW_W = lgge_pkg::ROW_W;
    localparam int CNT_W = lgge_pkg::CNT_W;
    localparam int HGT_W = lgge_pkg::HGT_W;
    localparam int WID_W = lgge_pkg::WID_W;
    localparam int PW    = lgge_pkg::PATTERN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_STEP,
        ST_DELIVER
    } state_t;

    state_t                        state_reg, state_next;
    logic [lgge_pkg::OP_W-1:0]     op_reg, op_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [COL_W-1:0]              mask_reg, mask_next;
    logic [COL_W-1:0]              data_reg, data_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [COL_W-1:0]              prev_reg, prev_next;
    logic [COL_W-1:0]              cur_reg, cur_next;
    logic                          live_reg, live_next;
    logic [COL_W-1:0]              res_data_reg, res_data_next;
    logic                          res_status_reg, res_status_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [lgge_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;
    logic [lgge_pkg::CFG_W-1:0]    width_reg, width_next;
    logic [lgge_pkg::CFG_W-1:0]    height_reg, height_next;

    logic [WID_W-1:0]              w_eff;
    logic [HGT_W-1:0]              h_eff;
    logic [COL_W-1:0]              col_mask;
    logic [lgge_pkg::ROW_IDX_W-1:0] in_row;
    logic [lgge_pkg::OFFSET_W-1:0] in_offset;
    logic [PW-1:0]                 in_cells;
    logic [PW-1:0]                 in_mask;
    logic [PW-1:0]                 shifted_mask;
    logic [PW-1:0]                 shifted_cells;
    logic                          in_accept;
    logic                          row_bad;
    logic                          out_free;
    logic [CNT_W-1:0]              wr_row_cnt;

    lgge_pkg::ram_req_t            ram_req;
    logic [COL_W-1:0]              ram_wr_data;
    logic [COL_W-1:0]              ram_rd_data;
    logic [COL_W-1:0]              down_row;
    logic [COL_W-1:0]              new_row;

    // Active area, with register values beyond the grid acting as the grid size.
    assign w_eff = (32'(width_reg) > lgge_pkg::MAX_COLUMNS) ?
                   WID_W'(lgge_pkg::MAX_COLUMNS) : WID_W'(width_reg);
    assign h_eff = (32'(height_reg) > lgge_pkg::MAX_ROWS) ?
                   HGT_W'(lgge_pkg::MAX_ROWS) : HGT_W'(height_reg);

    always_comb begin
        for (int c = 0; c < COL_W; c++) begin
            col_mask[c] = (32'(w_eff) > c);
        end
    end

    assign in_row    = s_tdata[lgge_pkg::ROW_IDX_LSB +: lgge_pkg::ROW_IDX_W];
    assign in_offset = s_tdata[lgge_pkg::OFFSET_LSB +: lgge_pkg::OFFSET_W];
    assign in_cells  = s_tdata[lgge_pkg::CELLS_LSB +: PW];
    assign in_mask   = s_tdata[lgge_pkg::MASK_LSB +: PW];

    assign shifted_mask  = in_mask << in_offset;
    assign shifted_cells = in_cells << in_offset;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign row_bad   = !(32'(in_row) < 32'(h_eff));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign down_row  = live_reg ? (ram_rd_data & col_mask) : '0;
    assign wr_row_cnt = cnt_reg - CNT_W'(2);

    lgge_row_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    lgge_row_unit u_rows (
        .up_row   (prev_reg),
        .mid_row  (cur_reg),
        .down_row (down_row),
        .col_mask (col_mask),
        .new_row  (new_row)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        row_next        = row_reg;
        mask_next       = mask_reg;
        data_next       = data_reg;
        cnt_next        = cnt_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        live_next       = live_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        ram_req         = '0;
        ram_wr_data     = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                lgge_pkg::REG_WIDTH:  width_next  = cfg_wr_data;
                lgge_pkg::REG_HEIGHT: height_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    op_next         = s_tuser;
                    row_next        = ROW_W'(in_row);
                    mask_next       = shifted_mask[COL_W-1:0] & col_mask;
                    data_next       = shifted_cells[COL_W-1:0];
                    res_data_next   = '0;
                    res_status_next = lgge_pkg::STATUS_DONE;
                    case (s_tuser)
                        lgge_pkg::OP_WRITE, lgge_pkg::OP_READ: begin
                            if (row_bad) begin
                                res_status_next = lgge_pkg::STATUS_BAD_ROW;
                                state_next      = ST_DELIVER;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = ROW_W'(in_row);
                                state_next      = ST_ACCESS;
                            end
                        end
                        lgge_pkg::OP_STEP: begin
                            cnt_next   = '0;
                            prev_next  = '0;
                            cur_next   = '0;
                            live_next  = 1'b0;
                            state_next = ST_STEP;
                        end
                        default: begin
                            state_next = ST_DELIVER;
                        end
                    endcase
                end
            end

            ST_ACCESS: begin
                if (op_reg == lgge_pkg::OP_READ) begin
                    res_data_next = ram_rd_data & col_mask;
                end else begin
                    // Masked cells take the pattern, all others keep what was stored.
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = row_reg;
                    ram_wr_data     = (ram_rd_data & ~mask_reg) | (data_reg & mask_reg);
                end
                state_next = ST_DELIVER;
            end

            ST_STEP: begin
                // The row read in the previous cycle is the lower neighbour of the row
                // two behind the read pointer; that row is written back here.
                if (32'(cnt_reg) >= 2) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = ROW_W'(wr_row_cnt);
                    ram_wr_data     = (32'(wr_row_cnt) < 32'(h_eff)) ? new_row : '0;
                end
                if (32'(cnt_reg) < lgge_pkg::MAX_ROWS) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = ROW_W'(cnt_reg);
                end
                prev_next = cur_reg;
                cur_next  = down_row;
                live_next = (32'(cnt_reg) < 32'(h_eff));
                if (32'(cnt_reg) == lgge_pkg::MAX_ROWS + 1) begin
                    state_next = ST_DELIVER;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DELIVER: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = lgge_pkg::M_TDATA_W'(res_data_reg);
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            prev_reg     <= '0;
            cur_reg      <= '0;
            live_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            width_reg    <= lgge_pkg::WIDTH_RESET;
            height_reg   <= lgge_pkg::HEIGHT_RESET;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            prev_reg     <= prev_next;
            cur_reg      <= cur_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
        end
        op_reg         <= op_next;
        row_reg        <= row_next;
        mask_reg       <= mask_next;
        data_reg       <= data_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The row store is written only by a row write or during a step.
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> (state_reg == ST_ACCESS || state_reg == ST_STEP))
        else $error("row store written outside a write or a step");

    // The step walk never runs past its last row.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (32'(cnt_reg) <= lgge_pkg::MAX_ROWS + 1))
        else $error("step counter past the end of the grid");

    // An accepted word always starts work.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    // A flagged row index never carries row data.
    a_flag_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == lgge_pkg::STATUS_BAD_ROW)) |-> (m_tdata_reg == '0))
        else $error("flagged result carries row data");

endmodule
